>>> design/cpos_pkg.sv
package cpos_pkg;

    // Fraction bits of the Q format used on every coordinate.
    localparam int FRAC_BITS = 16;

    // Squared length after the shift fits in 64 - FRAC_BITS unsigned bits.
    localparam int LEN_W = 64 - FRAC_BITS;
    // Dot product after the shift fits in 66 - FRAC_BITS signed bits.
    localparam int DOT_W = 66 - FRAC_BITS;
    // Product of a direction component and the factor t.
    localparam int PROD_W = 34 + FRAC_BITS;

    // Factor t of zero and of one in fixed point.
    localparam logic [FRAC_BITS:0] FX_ZERO = '0;
    localparam logic [FRAC_BITS:0] FX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};

    // Special cases found ahead of the division.
    typedef struct packed {
        logic degen;
        logic tzero;
        logic tone;
    } case_t;

    // Item as it moves along the row of division cells.
    typedef struct packed {
        logic [LEN_W-1:0]     rem;
        logic [LEN_W-1:0]     len;
        logic [FRAC_BITS-1:0] quo;
        case_t                flags;
        logic signed [31:0]   ox;
        logic signed [31:0]   oy;
        logic signed [31:0]   dx;
        logic signed [31:0]   dy;
    } div_t;

endpackage

>>> design/closest_point_on_segment.sv
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_stall   point_x/y, origin_x/y, dir_x/y
// output   out        out_valid / out_stall closest_x/y, degenerate
//
// One transfer is accepted every cycle while in_stall is low; each result passes through
// three front stages, one division cell per quotient bit, and two
// stages for scaling, adding and saturating.
// Reset clears only the stage valid bits; the data path has no reset.
// A stage holds only while the stage after it is full and cannot move, so bubbles close up
// and in_stall rises only when every stage holds an item and the output is stalled.
module closest_point_on_segment (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] closest_x,
    output logic signed [31:0] closest_y,
    output logic               degenerate
);
    import cpos_pkg::*;

    localparam int NSTG = FRAC_BITS + 5;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] ready;
    div_t            chain [0:FRAC_BITS];

    // A stage loads when it is empty or its item moves on.
    always_comb
    begin
        ready[NSTG-1] = !v_reg[NSTG-1] || !out_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            ready[i] = !v_reg[i] || ready[i+1];
        end
        v_next = v_reg;
        if (ready[0])
        begin
            v_next[0] = in_valid;
        end
        for (int i = 1; i < NSTG; i++)
        begin
            if (ready[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = v_reg[NSTG-1];

    // Offset, products, length and dot product.
    cpos_front u_front (
        .clk      (clk),
        .en       (ready[2:0]),
        .point_x  (point_x),
        .point_y  (point_y),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .div_out  (chain[0])
    );

    // Row of division cells, one quotient bit each.
    for (genvar g = 0; g < FRAC_BITS; g++)
    begin : g_cell
        cpos_div_cell u_cell (
            .clk     (clk),
            .en      (ready[3+g]),
            .div_in  (chain[g]),
            .div_out (chain[g+1])
        );
    end

    // Scaling, origin add and saturation.
    cpos_back u_back (
        .clk        (clk),
        .en         (ready[NSTG-1:NSTG-2]),
        .div_in     (chain[FRAC_BITS]),
        .closest_x  (closest_x),
        .closest_y  (closest_y),
        .degenerate (degenerate)
    );

`ifndef SYNTHESIS
    // An accepted transfer always lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v_reg[0])
        else $error("accepted transfer lost at first stage");

    // Input is held off only when the whole pipeline is full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&v_reg))
        else $error("input stalled with a free stage");

    // A stalled result is held unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(closest_x)
            && $stable(closest_y) && $stable(degenerate)))
        else $error("stalled result changed");
`endif

endmodule

>>> design/cpos_front.sv
module cpos_front (
    input  logic                   clk,
    input  logic [2:0]             en,
    input  logic signed [31:0]     point_x,
    input  logic signed [31:0]     point_y,
    input  logic signed [31:0]     origin_x,
    input  logic signed [31:0]     origin_y,
    input  logic signed [31:0]     dir_x,
    input  logic signed [31:0]     dir_y,
    output cpos_pkg::div_t         div_out
);
    import cpos_pkg::*;

    logic signed [32:0] offx_reg, offy_reg;
    logic signed [31:0] oxa_reg, oya_reg, dxa_reg, dya_reg;
    logic signed [63:0] sqx_reg, sqy_reg;
    logic signed [64:0] dpx_reg, dpy_reg;
    logic signed [31:0] oxb_reg, oyb_reg, dxb_reg, dyb_reg;
    div_t               div_reg;
    div_t               div_next;
    logic [LEN_W-1:0]   len;
    logic [DOT_W-1:0]   dot;

    // First stage: exact offset from the origin to the point.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            offx_reg <= 33'(point_x) - 33'(origin_x);
            offy_reg <= 33'(point_y) - 33'(origin_y);
            oxa_reg  <= origin_x;
            oya_reg  <= origin_y;
            dxa_reg  <= dir_x;
            dya_reg  <= dir_y;
        end
    end

    // Second stage: the four full-width products.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sqx_reg <= dxa_reg * dxa_reg;
            sqy_reg <= dya_reg * dya_reg;
            dpx_reg <= offx_reg * 65'(dxa_reg);
            dpy_reg <= offy_reg * 65'(dya_reg);
            oxb_reg <= oxa_reg;
            oyb_reg <= oya_reg;
            dxb_reg <= dxa_reg;
            dyb_reg <= dya_reg;
        end
    end

    // Shifted sums, and the cases that bypass the division.
    always_comb
    begin
        len = {1'b0, sqx_reg[62:FRAC_BITS]} + {1'b0, sqy_reg[62:FRAC_BITS]};
        dot = {dpx_reg[64], dpx_reg[64:FRAC_BITS]} + {dpy_reg[64], dpy_reg[64:FRAC_BITS]};
        div_next.rem         = dot[LEN_W-1:0];
        div_next.len         = len;
        div_next.quo         = '0;
        div_next.flags.degen = (len == '0);
        div_next.flags.tzero = dot[DOT_W-1] || (dot == '0);
        div_next.flags.tone  = !dot[DOT_W-1] && ({2'b00, len} <= dot);
        div_next.ox          = oxb_reg;
        div_next.oy          = oyb_reg;
        div_next.dx          = dxb_reg;
        div_next.dy          = dyb_reg;
    end

    // Third stage: registered length, dot remainder and flags.
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

>>> design/cpos_div_cell.sv
module cpos_div_cell (
    input  logic            clk,
    input  logic            en,
    input  cpos_pkg::div_t  div_in,
    output cpos_pkg::div_t  div_out
);
    import cpos_pkg::*;

    logic [LEN_W:0] rem2;
    logic           ge;
    div_t           div_reg;
    div_t           div_next;

    // One restoring step: shift the remainder and try to take the length off.
    always_comb
    begin
        rem2     = {div_in.rem, 1'b0};
        ge       = (rem2 >= {1'b0, div_in.len});
        div_next = div_in;
        if (ge)
        begin
            div_next.rem = LEN_W'(rem2 - {1'b0, div_in.len});
        end
        else
        begin
            div_next.rem = rem2[LEN_W-1:0];
        end
        div_next.quo = {div_in.quo[FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

>>> design/cpos_back.sv
module cpos_back (
    input  logic               clk,
    input  logic [1:0]         en,
    input  cpos_pkg::div_t     div_in,
    output logic signed [31:0] closest_x,
    output logic signed [31:0] closest_y,
    output logic               degenerate
);
    import cpos_pkg::*;

    logic [FRAC_BITS:0]          t;
    logic signed [FRAC_BITS+1:0] ts;
    logic signed [PROD_W-1:0]    prx_reg, pry_reg;
    logic signed [31:0]          ox_reg, oy_reg;
    logic                        degen_reg;
    logic signed [31:0]          cx_reg, cy_reg;
    logic                        dg_reg;
    logic signed [34:0]          sum_x, sum_y;

    // Pick the factor t from the quotient or from a bypass case.
    always_comb
    begin
        if (div_in.flags.degen || div_in.flags.tzero)
        begin
            t = FX_ZERO;
        end
        else if (div_in.flags.tone)
        begin
            t = FX_ONE;
        end
        else
        begin
            t = {1'b0, div_in.quo};
        end
        ts = {1'b0, t};
    end

    // Scale the direction by t.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prx_reg   <= PROD_W'(div_in.dx) * PROD_W'(ts);
            pry_reg   <= PROD_W'(div_in.dy) * PROD_W'(ts);
            ox_reg    <= div_in.ox;
            oy_reg    <= div_in.oy;
            degen_reg <= div_in.flags.degen;
        end
    end

    // Add the origin to the shifted products.
    always_comb
    begin
        sum_x = {{3{ox_reg[31]}}, ox_reg} + {prx_reg[PROD_W-1], prx_reg[PROD_W-1:FRAC_BITS]};
        sum_y = {{3{oy_reg[31]}}, oy_reg} + {pry_reg[PROD_W-1], pry_reg[PROD_W-1:FRAC_BITS]};
    end

    // Output register with saturation to 32 bits.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            if (sum_x[34:31] == 4'b0000 || sum_x[34:31] == 4'b1111)
            begin
                cx_reg <= sum_x[31:0];
            end
            else
            begin
                cx_reg <= sum_x[34] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
            end
            if (sum_y[34:31] == 4'b0000 || sum_y[34:31] == 4'b1111)
            begin
                cy_reg <= sum_y[31:0];
            end
            else
            begin
                cy_reg <= sum_y[34] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
            end
            dg_reg <= degen_reg;
        end
    end

    assign closest_x  = cx_reg;
    assign closest_y  = cy_reg;
    assign degenerate = dg_reg;

endmodule
